FILE: hdl/svm_pkg.sv
// Shared types and constants of the stack machine execute unit.
package svm_pkg;

  localparam int DATA_W   = 32;
  localparam int IP_W     = 16;
  localparam int NUM_REGS = 12;
  localparam int GP_REGS  = NUM_REGS - 2;
  localparam int RIDX_W   = 4;
  localparam int DCNT_W   = 6;

  // Opcodes.
  localparam logic [3:0] OP_HLT = 4'd0;
  localparam logic [3:0] OP_PSH = 4'd1;
  localparam logic [3:0] OP_POP = 4'd2;
  localparam logic [3:0] OP_ADD = 4'd3;
  localparam logic [3:0] OP_MUL = 4'd4;
  localparam logic [3:0] OP_DIV = 4'd5;
  localparam logic [3:0] OP_SUB = 4'd6;
  localparam logic [3:0] OP_SLT = 4'd7;
  localparam logic [3:0] OP_MOV = 4'd8;
  localparam logic [3:0] OP_SET = 4'd9;
  localparam logic [3:0] OP_LOG = 4'd10;
  localparam logic [3:0] OP_IF  = 4'd11;
  localparam logic [3:0] OP_IFN = 4'd12;
  localparam logic [3:0] OP_GLD = 4'd13;
  localparam logic [3:0] OP_GPT = 4'd14;
  localparam logic [3:0] OP_NOP = 4'd15;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_OP  = 3'd1;
  localparam logic [2:0] ST_DIV0    = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_UNDER   = 3'd4;
  localparam logic [2:0] ST_BAD_REG = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_top;
    logic rd_next;
    logic calc;
    logic div_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_div;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

FILE: hdl/svm_if.sv
// Handshake channel interfaces for instructions and results.
interface svm_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [31:0] operand_one;
  logic [31:0] operand_two;
  logic [15:0] operand_three;
  modport source (output valid, mode, operand_one, operand_two, operand_three, input ready);
  modport sink   (input valid, mode, operand_one, operand_two, operand_three, output ready);
endinterface

interface svm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_ip;
  logic        log_valid;
  logic [31:0] log_value;
  logic        halted;
  logic [2:0]  status;
  modport source (output valid, next_ip, log_valid, log_value, halted, status, input ready);
  modport sink   (input valid, next_ip, log_valid, log_value, halted, status, output ready);
endinterface

FILE: hdl/svm_ctrl.sv
// Controller state machine sequencing each instruction through the datapath.
module svm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  svm_pkg::sts_t sts,
  output svm_pkg::cmd_t cmd
);
  import svm_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_TOP  = 3'd1;
  localparam logic [2:0] S_RD_NEXT = 3'd2;
  localparam logic [2:0] S_CALC    = 3'd3;
  localparam logic [2:0] S_DIV     = 3'd4;
  localparam logic [2:0] S_COMMIT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD_TOP;
        end
      end
      S_RD_TOP: begin
        cmd.rd_top = 1'b1;
        state_nxt  = S_RD_NEXT;
      end
      S_RD_NEXT: begin
        cmd.rd_next = 1'b1;
        state_nxt   = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.is_div ? S_DIV : S_COMMIT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/svm_datapath.sv
// Datapath: register file, stack memory, divider, execution and result register.
module svm_datapath #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  svm_pkg::cmd_t             cmd,
  output svm_pkg::sts_t             sts,
  input  logic [3:0]                mode,
  input  logic [svm_pkg::DATA_W-1:0] operand_one,
  input  logic [svm_pkg::DATA_W-1:0] operand_two,
  input  logic [svm_pkg::IP_W-1:0]   operand_three,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [svm_pkg::IP_W-1:0]   next_ip,
  output logic                      log_valid,
  output logic [svm_pkg::DATA_W-1:0] log_value,
  output logic                      halted,
  output logic [2:0]                status
);
  import svm_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Latched item.
  logic [3:0]        op_r;
  logic [DATA_W-1:0] op1_r, op2_r;
  logic [IP_W-1:0]   tgt_r;

  // Architectural state.
  logic [DATA_W-1:0] rf_r [GP_REGS];
  logic [IP_W-1:0]   ip_r;
  logic [CW-1:0]     count_r;
  logic              halt_r;
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] mem_q;

  // Operands and intermediate results.
  logic [DATA_W-1:0] a_r, b_r, c_r;
  logic [DATA_W-1:0] prod;

  // Divider.
  logic [DATA_W:0]   rem_r;
  logic [DATA_W-1:0] quo_r, den_r;
  logic              neg_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [DATA_W:0]   rem_sh, rem_sub;

  // Result register.
  logic              out_valid_r;
  logic [IP_W-1:0]   res_ip_r;
  logic              res_lval_r, res_halt_r;
  logic [DATA_W-1:0] res_lv_r;
  logic [2:0]        res_st_r;

  // Commit decode.
  logic [2:0]        st;
  logic [IP_W-1:0]   nip;
  logic              lval, halt_set, rf_we, arith_we, mem_we;
  logic [DATA_W-1:0] lv, rf_wdata, mem_wdata, rval, c_fin, quo_s;
  logic [RIDX_W-1:0] rf_waddr;
  logic [AW-1:0]     mem_waddr, rd_addr;
  logic [CW-1:0]     cnt_nxt;
  logic              rd1, wr1, wr2, full, empty, lt2;

  assign sts.is_div   = (op_r == OP_DIV);
  assign sts.div_done = (dcnt_r == '0);
  assign sts.out_busy = out_valid_r && !out_ready;

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= mode;
      op1_r <= operand_one;
      op2_r <= operand_two;
      tgt_r <= operand_three;
    end
  end

  // Stack memory with registered read port.
  assign rd_addr = cmd.rd_top ? AW'(count_r - CW'(1)) : AW'(count_r - CW'(2));

  always_ff @(posedge clk) begin
    if (cmd.rd_top || cmd.rd_next) begin
      mem_q <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Operand capture and arithmetic; mem_q holds the second entry in the calc step.
  assign prod = DATA_W'(mem_q * a_r);

  always_ff @(posedge clk) begin
    if (cmd.rd_next) begin
      a_r <= mem_q;
    end
    if (cmd.calc) begin
      b_r <= mem_q;
      case (op_r)
        OP_ADD:  c_r <= mem_q + a_r;
        OP_SUB:  c_r <= mem_q - a_r;
        OP_MUL:  c_r <= prod;
        default: c_r <= {{(DATA_W-1){1'b0}}, ($signed(a_r) < $signed(mem_q))};
      endcase
    end
  end

  // Restoring divider on magnitudes, one quotient bit a cycle.
  assign rem_sh  = {rem_r[DATA_W-1:0], quo_r[DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.calc && op_r == OP_DIV) begin
      dcnt_r <= DCNT_W'(DATA_W);
    end else if (cmd.div_step && dcnt_r != '0) begin
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      rem_r <= '0;
      quo_r <= mem_q[DATA_W-1] ? (~mem_q + DATA_W'(1)) : mem_q;
      den_r <= a_r[DATA_W-1] ? (~a_r + DATA_W'(1)) : a_r;
      neg_r <= mem_q[DATA_W-1] ^ a_r[DATA_W-1];
    end else if (cmd.div_step && dcnt_r != '0) begin
      if (!rem_sub[DATA_W]) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quo_s = neg_r ? (~quo_r + DATA_W'(1)) : quo_r;
  assign c_fin = (op_r == OP_DIV) ? quo_s : c_r;

  // Register read including the instruction address and stack pointer views.
  always_comb begin
    if (op1_r[RIDX_W-1:0] < RIDX_W'(GP_REGS)) begin
      rval = rf_r[op1_r[RIDX_W-1:0]];
    end else if (op1_r[RIDX_W-1:0] == RIDX_W'(GP_REGS)) begin
      rval = DATA_W'(ip_r);
    end else begin
      rval = DATA_W'(count_r) - DATA_W'(1);
    end
  end

  assign rd1   = (op1_r < DATA_W'(NUM_REGS));
  assign wr1   = (op1_r < DATA_W'(GP_REGS));
  assign wr2   = (op2_r < DATA_W'(GP_REGS));
  assign full  = (count_r >= CW'(STACK_DEPTH));
  assign empty = (count_r == '0);
  assign lt2   = (count_r < CW'(2));

  // Execution of the latched instruction against the current state.
  always_comb begin
    st        = ST_OK;
    nip       = ip_r;
    lval      = 1'b0;
    lv        = '0;
    halt_set  = 1'b0;
    rf_we     = 1'b0;
    arith_we  = 1'b0;
    rf_waddr  = op1_r[RIDX_W-1:0];
    rf_wdata  = rval;
    mem_we    = 1'b0;
    mem_waddr = AW'(count_r);
    mem_wdata = op1_r;
    cnt_nxt   = count_r;
    if (!halt_r) begin
      case (op_r)
        OP_HLT: begin
          halt_set = 1'b1;
          nip      = ip_r + IP_W'(1);
        end
        OP_PSH: begin
          if (full) begin
            st = ST_OVER;
          end else begin
            mem_we  = 1'b1;
            cnt_nxt = count_r + CW'(1);
            nip     = ip_r + IP_W'(2);
          end
        end
        OP_POP: begin
          if (empty) begin
            st = ST_UNDER;
          end else begin
            cnt_nxt = count_r - CW'(1);
            nip     = ip_r + IP_W'(1);
          end
        end
        OP_ADD, OP_MUL, OP_DIV, OP_SUB, OP_SLT: begin
          if (lt2) begin
            st = ST_UNDER;
          end else if (op_r == OP_DIV && a_r == '0) begin
            st = ST_DIV0;
          end else begin
            arith_we  = (op_r != OP_SLT);
            mem_we    = 1'b1;
            mem_waddr = AW'(count_r - CW'(2));
            mem_wdata = c_fin;
            cnt_nxt   = count_r - CW'(1);
            nip       = ip_r + IP_W'(1);
          end
        end
        OP_MOV: begin
          if (!rd1 || !wr2) begin
            st = ST_BAD_REG;
          end else begin
            rf_we    = 1'b1;
            rf_waddr = op2_r[RIDX_W-1:0];
            nip      = ip_r + IP_W'(3);
          end
        end
        OP_SET: begin
          if (!wr1) begin
            st = ST_BAD_REG;
          end else begin
            rf_we    = 1'b1;
            rf_wdata = op2_r;
            nip      = ip_r + IP_W'(3);
          end
        end
        OP_LOG: begin
          if (!rd1) begin
            st = ST_BAD_REG;
          end else begin
            lval = 1'b1;
            lv   = rval;
            nip  = ip_r + IP_W'(2);
          end
        end
        OP_IF, OP_IFN: begin
          if (!rd1) begin
            st = ST_BAD_REG;
          end else if ((rval == op2_r) == (op_r == OP_IF)) begin
            nip = tgt_r;
          end else begin
            nip = ip_r + IP_W'(4);
          end
        end
        OP_GLD: begin
          if (!rd1) begin
            st = ST_BAD_REG;
          end else if (full) begin
            st = ST_OVER;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = rval;
            cnt_nxt   = count_r + CW'(1);
            nip       = ip_r + IP_W'(2);
          end
        end
        OP_GPT: begin
          if (!wr1) begin
            st = ST_BAD_REG;
          end else if (empty) begin
            st = ST_UNDER;
          end else begin
            rf_we    = 1'b1;
            rf_wdata = a_r;
            nip      = ip_r + IP_W'(2);
          end
        end
        default: nip = ip_r + IP_W'(1);
      endcase
    end
    if (!cmd.commit) begin
      mem_we = 1'b0;
    end
  end

  // Architectural state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GP_REGS; i++) begin
        rf_r[i] <= '0;
      end
      ip_r    <= '0;
      count_r <= '0;
      halt_r  <= 1'b0;
    end else if (cmd.commit) begin
      ip_r    <= nip;
      count_r <= cnt_nxt;
      if (halt_set) begin
        halt_r <= 1'b1;
      end
      if (rf_we) begin
        rf_r[rf_waddr] <= rf_wdata;
      end
      if (arith_we) begin
        rf_r[0] <= a_r;
        rf_r[1] <= b_r;
        rf_r[2] <= c_fin;
      end
    end
  end

  // Result register; a transfer frees it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_ip_r   <= nip;
      res_lval_r <= lval;
      res_lv_r   <= lv;
      res_halt_r <= halt_r | halt_set;
      res_st_r   <= st;
    end
  end

  assign out_valid = out_valid_r;
  assign next_ip   = res_ip_r;
  assign log_valid = res_lval_r;
  assign log_value = res_lv_r;
  assign halted    = res_halt_r;
  assign status    = res_st_r;

endmodule

FILE: hdl/stack_vm_execute_unit.sv
// Top level of the stack machine execute unit.
// A result is offered after an instruction transfer once the two stack reads through the
// single registered memory port, the calculation, the bit-serial divider for divide, and
// the commit are done. A new instruction is taken only after the previous one commits.
// A waiting result sits in the output register while the next instruction is taken.
// Reset (synchronous, rst_n low) clears registers, instruction pointer, stack count and halt.
module stack_vm_execute_unit #(
  parameter int STACK_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  svm_in_if.sink        in_ch,
  svm_out_if.source     out_ch
);
  import svm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  svm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  svm_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (in_ch.mode),
    .operand_one   (in_ch.operand_one),
    .operand_two   (in_ch.operand_two),
    .operand_three (in_ch.operand_three),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .next_ip       (out_ch.next_ip),
    .log_valid     (out_ch.log_valid),
    .log_value     (out_ch.log_value),
    .halted        (out_ch.halted),
    .status        (out_ch.status)
  );

endmodule

FILE: hdl/svm_checker.sv
// Port-level checks on the execute unit's results, bound to the top level.
module svm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        log_valid,
  input logic [31:0] log_value,
  input logic        halted,
  input logic [2:0]  status
);
  import svm_pkg::*;

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  // Status stays within the defined codes.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status != 3'd6 && status != 3'd7)) else $error("undefined status");

  // A logged value comes only from a clean, running instruction.
  a_log_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && log_valid |-> (status == ST_OK && !halted)) else $error("log with fault");

  // No log means a zero log value.
  a_log_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !log_valid |-> log_value == '0) else $error("stray log value");

  // A halted machine reports no fault.
  a_halt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && halted |-> status == ST_OK) else $error("fault after halt");

endmodule

bind stack_vm_execute_unit svm_checker u_svm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .log_valid (out_ch.log_valid),
  .log_value (out_ch.log_value),
  .halted    (out_ch.halted),
  .status    (out_ch.status)
);
